/* src/ptq_pkg.sv */
// ptq_pkg: shared types, constants and helpers for periodic_timer_queue.
// No dependencies; compiled first.
package ptq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MODE_W         = 2;
    localparam int ID_W           = 4;
    localparam int PER_W          = 31;
    localparam int TIME_W         = 32;
    localparam int STATUS_W       = 2;

    localparam logic [PER_W-1:0] MAX_PERIOD_RST = 31'd86400000;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_POP    = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_DUP       = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_TOO_LARGE = 2'd3
    } status_t;

    // one timer slot as stored in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [PER_W-1:0]  period;
        logic              cycled;
    } slot_t;

    // a strictly before b, by sign of the wrapped difference
    function automatic logic time_before(input logic [TIME_W-1:0] a,
                                         input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage

/* src/ptq_if.sv */
// ptq_in_if / ptq_out_if: valid/ready channels of periodic_timer_queue.
// Depends on ptq_pkg for field widths.
interface ptq_in_if;
    logic                           valid;
    logic                           ready;
    logic [ptq_pkg::MODE_W-1:0]     mode;
    logic [ptq_pkg::ID_W-1:0]       task_id;
    logic [ptq_pkg::PER_W-1:0]      period_ms;
    logic                           cycled;
    logic [ptq_pkg::TIME_W-1:0]     now_ms;

    modport source (output valid, mode, task_id, period_ms, cycled, now_ms, input ready);
    modport sink   (input valid, mode, task_id, period_ms, cycled, now_ms, output ready);
endinterface

interface ptq_out_if;
    logic                           valid;
    logic                           ready;
    logic [ptq_pkg::STATUS_W-1:0]   status;
    logic [ptq_pkg::ID_W-1:0]       found_id;
    logic [ptq_pkg::PER_W-1:0]      remaining_ms;
    logic [ptq_pkg::PER_W-1:0]      found_period;
    logic                           found_cycled;

    modport source (output valid, status, found_id, remaining_ms, found_period, found_cycled,
                    input ready);
    modport sink   (input valid, status, found_id, remaining_ms, found_period, found_cycled,
                    output ready);
endinterface

/* src/periodic_timer_queue.sv */
// periodic_timer_queue: timer table with add/remove/peek/pop and periodic reload.
// Depends on ptq_pkg, ptq_in_if / ptq_out_if and ptq_slot_ram.
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+-------------------------------------------
//   req     | in  | valid/ready        | mode, task_id, period_ms, cycled, now_ms
//   rsp     | out | valid/ready        | status, found_id, remaining_ms,
//           |     |                    |   found_period, found_cycled
//   cfg     | in  | cfg_we, no ready   | cfg_wdata = max_period_ms
//
// Add and remove: accept, then check and write in S_EXEC, which loads the result.
// Peek and pop: accept, S_SCAN, then S_FINISH; the scan reads the slot
//   memory one entry per cycle through its single read port, and that sets the rate.
// One word is in flight at a time; req.ready is high only while idle.
// A finished result waits in the output register; a new word is accepted meanwhile,
//   and its final cycle holds until the output register is free.
// Reset clears all valid marks and loads max_period_ms = 86400000; no clearing pass.
module periodic_timer_queue #(
    parameter  int NUM_TIMERS = ptq_pkg::NUM_TIMERS_DEF,
    localparam int IDX_W      = $clog2(NUM_TIMERS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ptq_pkg::PER_W-1:0]   cfg_wdata,
    ptq_in_if.sink                      req,
    ptq_out_if.source                   rsp
);
    import ptq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,     // add / remove: check and write
        S_SCAN,     // peek / pop: walk the slot memory
        S_FINISH    // peek / pop: report, pop write-back
    } state_t;

    state_t             state_reg;

    // latched request word
    mode_t              mode_reg;
    logic [ID_W-1:0]    id_reg;
    logic [PER_W-1:0]   period_reg;
    logic               cycled_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [PER_W-1:0]   max_period_reg;
    logic [NUM_TIMERS-1:0] valid_reg;

    // scan pipeline: issue address, compare in the following cycle
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               issue_done_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               best_hit_reg;
    logic [IDX_W-1:0]   best_id_reg;
    slot_t              best_reg;

    // output register
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [PER_W-1:0]   out_rem_reg;
    logic [PER_W-1:0]   out_per_reg;
    logic               out_cyc_reg;

    // slot memory port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    slot_t              ram_wdata;
    slot_t              ram_rdata;

    logic               out_free;
    logic               out_load;
    logic               id_in_range;
    logic [IDX_W-1:0]   id_idx;
    logic               id_valid;
    logic               cmp_hit;
    logic [TIME_W-1:0]  rem_diff;
    logic               rearm;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    ptq_slot_ram #(
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_id     = out_id_reg;
    assign rsp.remaining_ms = out_rem_reg;
    assign rsp.found_period = out_per_reg;
    assign rsp.found_cycled = out_cyc_reg;

    assign out_free    = !out_valid_reg || rsp.ready;
    // a result is loaded into the output register this cycle
    assign out_load    = ((state_reg == S_EXEC) || (state_reg == S_FINISH)) && out_free;
    assign id_in_range = (int'(id_reg) < NUM_TIMERS);
    assign id_idx      = IDX_W'(id_reg);
    // out-of-range ids never reach the valid array
    assign id_valid    = id_in_range && valid_reg[id_idx];

    // strictly earlier wins, so ties keep the lowest id
    assign cmp_hit  = valid_reg[cmp_idx_reg] &&
                      (!best_hit_reg || time_before(ram_rdata.expiry, best_reg.expiry));
    assign rem_diff = best_reg.expiry - now_reg;
    // pop of a cycled timer keeps the slot and moves its expiry
    assign rearm    = (mode_reg == MODE_POP) && best_hit_reg && best_reg.cycled;

    // memory writes: add in S_EXEC, re-arm in S_FINISH
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = id_idx;
        ram_wdata = '{expiry: now_reg + TIME_W'(period_reg),
                      period: period_reg,
                      cycled: cycled_reg};
        case (state_reg)
            S_EXEC:
            begin
                ram_we = out_free && (mode_reg == MODE_ADD) && id_in_range && !id_valid &&
                         (period_reg < max_period_reg);
            end
            S_FINISH:
            begin
                ram_we    = out_free && rearm;
                ram_waddr = best_id_reg;
                ram_wdata = '{expiry: now_reg + TIME_W'(best_reg.period),
                              period: best_reg.period,
                              cycled: best_reg.cycled};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_period_reg <= MAX_PERIOD_RST;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            best_hit_reg   <= 1'b0;
            scan_idx_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_period_reg <= cfg_wdata;
            end
            if (rsp.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg       <= mode_t'(req.mode);
                        id_reg         <= req.task_id;
                        period_reg     <= req.period_ms;
                        cycled_reg     <= req.cycled;
                        now_reg        <= req.now_ms;
                        scan_idx_reg   <= '0;
                        issue_done_reg <= 1'b0;
                        cmp_vld_reg    <= 1'b0;
                        best_hit_reg   <= 1'b0;
                        if (mode_t'(req.mode) inside {MODE_PEEK, MODE_POP})
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                end

                S_EXEC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= '0;
                        out_rem_reg   <= '0;
                        out_per_reg   <= '0;
                        out_cyc_reg   <= 1'b0;
                        if (mode_reg == MODE_ADD)
                        begin
                            if (!id_in_range)
                            begin
                                out_status_reg <= STAT_NOT_FOUND;
                            end
                            else if (id_valid)
                            begin
                                out_status_reg <= STAT_DUP;
                            end
                            else if (period_reg >= max_period_reg)
                            begin
                                out_status_reg <= STAT_TOO_LARGE;
                            end
                            else
                            begin
                                out_status_reg    <= STAT_OK;
                                valid_reg[id_idx] <= 1'b1;
                            end
                        end
                        else
                        begin
                            if (!id_valid)
                            begin
                                out_status_reg <= STAT_NOT_FOUND;
                            end
                            else
                            begin
                                out_status_reg    <= STAT_OK;
                                valid_reg[id_idx] <= 1'b0;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end

                S_SCAN:
                begin
                    // issue side
                    cmp_vld_reg <= !issue_done_reg;
                    cmp_idx_reg <= scan_idx_reg;
                    if (!issue_done_reg)
                    begin
                        if (scan_idx_reg == LAST_IDX)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            scan_idx_reg <= scan_idx_reg + 1'b1;
                        end
                    end
                    // compare side
                    if (cmp_vld_reg)
                    begin
                        if (cmp_hit)
                        begin
                            best_hit_reg <= 1'b1;
                            best_id_reg  <= cmp_idx_reg;
                            best_reg     <= ram_rdata;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (best_hit_reg)
                        begin
                            out_status_reg <= STAT_OK;
                            out_id_reg     <= ID_W'(best_id_reg);
                            out_rem_reg    <= rem_diff[TIME_W-1] ? '0 : rem_diff[PER_W-1:0];
                            out_per_reg    <= best_reg.period;
                            out_cyc_reg    <= best_reg.cycled;
                            if ((mode_reg == MODE_POP) && !best_reg.cycled)
                            begin
                                valid_reg[best_id_reg] <= 1'b0;
                            end
                        end
                        else
                        begin
                            out_status_reg <= STAT_NOT_FOUND;
                            out_id_reg     <= '0;
                            out_rem_reg    <= '0;
                            out_per_reg    <= '0;
                            out_cyc_reg    <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // an accepted word always starts work
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("accepted word did not leave idle");

    // the slot memory is written only in the check or report cycles
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_EXEC) || (state_reg == S_FINISH)))
        else $error("slot memory written outside a write phase");

    // the scan result always points at a live slot
    a_best_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINISH) && best_hit_reg) |-> valid_reg[best_id_reg])
        else $error("earliest slot is not valid");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready && (state_reg == S_FINISH)) |=> (state_reg == S_FINISH))
        else $error("report left while output register busy");
`endif

endmodule

/* src/ptq_slot_ram.sv */
// ptq_slot_ram: single-port-write, single-port-read slot memory, registered read.
// Depends on ptq_pkg (slot_t).
module ptq_slot_ram #(
    parameter  int DEPTH  = ptq_pkg::NUM_TIMERS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  ptq_pkg::slot_t      wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output ptq_pkg::slot_t      rdata
);
    import ptq_pkg::*;

    slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sim/periodic_timer_queue_tb.sv */
`timescale 1ns / 100ps
// periodic_timer_queue_tb: self-checking bench for the timer table (add/remove/peek/pop).
// Depends on ptq_pkg, ptq_in_if / ptq_out_if and the periodic_timer_queue RTL.
// A directed script runs first, then random phases under several period limits.
module periodic_timer_queue_tb;
    import ptq_pkg::*;

    localparam int NUM           = NUM_TIMERS_DEF;
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off, forces input stall
    localparam int QUIET_LIMIT   = 3000;   // cycles with no handshake before giving up
    localparam int PHASE_WORDS   = 150;
    localparam int CALM_WORDS    = 120;

    // one request word as the bench sees it
    typedef struct packed {
        mode_t             mode;
        logic [ID_W-1:0]   task_id;
        logic [PER_W-1:0]  period_ms;
        logic              cycled;
        logic [TIME_W-1:0] now_ms;
    } timer_cmd_t;

    // one response word
    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   found_id;
        logic [PER_W-1:0]  remaining_ms;
        logic [PER_W-1:0]  found_period;
        logic              found_cycled;
    } timer_rsp_t;

    // directed script row: either a limit write or a request word,
    // optionally with a hand-written expected status (other fields zero)
    typedef struct {
        bit               is_limit;
        logic [PER_W-1:0] limit;
        timer_cmd_t       cmd;
        bit               typed;
        timer_rsp_t       want;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [PER_W-1:0] cfg_wdata;

    ptq_in_if  req_if ();
    ptq_out_if rsp_if ();

    periodic_timer_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // shadow timer table, updated as each request word is accepted
    logic              slot_live   [NUM];
    logic [TIME_W-1:0] slot_expiry [NUM];
    logic [PER_W-1:0]  slot_per    [NUM];
    logic              slot_cyc    [NUM];
    logic [PER_W-1:0]  max_limit;

    timer_rsp_t    rsp_q [$];      // responses still owed by the block, oldest first
    script_row_t   script [$];
    logic [TIME_W-1:0] wall;       // running wall clock for random words
    int unsigned   mismatches;
    int unsigned   quiet;
    bit            calm;           // no idling on either side while set
    bit            hold_req;       // asks the receiver for one long hold-off

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: applies one word to the shadow table, returns the response
    // ------------------------------------------------------------------
    function automatic timer_rsp_t predict_word(timer_cmd_t c);
        timer_rsp_t        r;
        int                best;
        logic [TIME_W-1:0] d;
        r = '0;
        r.status = STAT_OK;
        case (c.mode)
            MODE_ADD:
            begin
                // duplicate check wins over the period check
                if (slot_live[c.task_id])
                    r.status = STAT_DUP;
                else if (c.period_ms >= max_limit)
                    r.status = STAT_TOO_LARGE;
                else
                begin
                    slot_live[c.task_id]   = 1'b1;
                    slot_expiry[c.task_id] = c.now_ms + {1'b0, c.period_ms};
                    slot_per[c.task_id]    = c.period_ms;
                    slot_cyc[c.task_id]    = c.cycled;
                end
            end
            MODE_REMOVE:
            begin
                if (!slot_live[c.task_id])
                    r.status = STAT_NOT_FOUND;
                else
                    slot_live[c.task_id] = 1'b0;
            end
            default:
            begin
                // scan upward, replace only when strictly earlier: ties go to lowest id
                best = -1;
                for (int i = 0; i < NUM; i++)
                begin
                    if (slot_live[i])
                    begin
                        d = slot_expiry[i] - slot_expiry[(best < 0) ? 0 : best];
                        if (best < 0 || d[TIME_W-1])
                            best = i;
                    end
                end
                if (best < 0)
                    r.status = STAT_NOT_FOUND;
                else
                begin
                    d = slot_expiry[best] - c.now_ms;
                    r.found_id     = best[ID_W-1:0];
                    r.remaining_ms = d[TIME_W-1] ? '0 : d[PER_W-1:0];
                    r.found_period = slot_per[best];
                    r.found_cycled = slot_cyc[best];
                    if (c.mode == MODE_POP)
                    begin
                        // re-arm uses the stored period, whatever the limit is now
                        if (slot_cyc[best])
                            slot_expiry[best] = c.now_ms + {1'b0, slot_per[best]};
                        else
                            slot_live[best] = 1'b0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Script row builders
    // ------------------------------------------------------------------
    function automatic script_row_t op(mode_t m, logic [ID_W-1:0] id, logic [PER_W-1:0] per,
                                       logic cyc, logic [TIME_W-1:0] now);
        script_row_t s;
        s.is_limit = 1'b0;
        s.limit    = '0;
        s.cmd      = '{m, id, per, cyc, now};
        s.typed    = 1'b0;
        s.want     = '0;
        return s;
    endfunction

    // row whose response is known on sight: given status, all other fields zero
    function automatic script_row_t op_is(mode_t m, logic [ID_W-1:0] id, logic [PER_W-1:0] per,
                                          logic cyc, logic [TIME_W-1:0] now, status_t st);
        script_row_t s;
        s = op(m, id, per, cyc, now);
        s.typed       = 1'b1;
        s.want.status = st;
        return s;
    endfunction

    function automatic script_row_t limit_row(logic [PER_W-1:0] v);
        script_row_t s;
        s = op(MODE_PEEK, '0, '0, 1'b0, '0);
        s.is_limit = 1'b1;
        s.limit    = v;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Random word generation
    // ------------------------------------------------------------------
    function automatic logic [ID_W-1:0] pick_id(bit want_live);
        int ids [$];
        for (int i = 0; i < NUM; i++)
            if (slot_live[i] == want_live)
                ids.push_back(i);
        if (ids.size() == 0)
            return ID_W'($urandom_range(NUM - 1));
        return ID_W'(ids[$urandom_range(ids.size() - 1)]);
    endfunction

    function automatic timer_cmd_t next_cmd();
        timer_cmd_t c;
        int         roll;
        // wall clock mostly creeps forward; sometimes it jumps far or anywhere
        case ($urandom_range(19))
            0:       wall = $urandom;
            1:       wall = wall + 32'h7FFF_FFF0 + $urandom_range(32);
            default: wall = wall + $urandom_range(400);
        endcase
        c.now_ms    = wall;
        c.cycled    = 1'($urandom_range(1));
        c.task_id   = ID_W'($urandom_range(NUM - 1));
        c.period_ms = PER_W'($urandom);    // noise for modes that ignore it
        roll = $urandom_range(99);
        if (roll < 35)
        begin
            c.mode = MODE_ADD;
            if ($urandom_range(9) < 8)
                c.task_id = pick_id(1'b0);
            case ($urandom_range(19))
                12, 13, 14: c.period_ms = max_limit - 1'b1;
                15, 16:     c.period_ms = max_limit;    // just too large
                17, 18, 19: c.period_ms = PER_W'($urandom);
                default:    c.period_ms = PER_W'($urandom_range(0,
                                (max_limit > 2000) ? 2000 : max_limit - 1));
            endcase
        end
        else if (roll < 50)
        begin
            c.mode = MODE_REMOVE;
            if ($urandom_range(9) < 8)
                c.task_id = pick_id(1'b1);
        end
        else if (roll < 72)
            c.mode = MODE_PEEK;
        else
            c.mode = MODE_POP;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // offer one word, wait for the handshake, then log what the block owes
    task automatic send_word(timer_cmd_t c, bit typed, timer_rsp_t want);
        timer_rsp_t pred;
        if (!calm)
            while ($urandom_range(99) < 17)
            begin
                req_if.valid <= 1'b0;
                @(posedge clk);
            end
        req_if.valid     <= 1'b1;
        req_if.mode      <= c.mode;
        req_if.task_id   <= c.task_id;
        req_if.period_ms <= c.period_ms;
        req_if.cycled    <= c.cycled;
        req_if.now_ms    <= c.now_ms;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pred = predict_word(c);
        rsp_q.push_back(typed ? want : pred);
    endtask

    // limit register is written only with the block drained
    task automatic write_limit(logic [PER_W-1:0] v);
        req_if.valid <= 1'b0;
        while (rsp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        max_limit = v;
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            else
                rsp_if.ready <= calm || ($urandom_range(99) >= 17);
        end
    end

    // ------------------------------------------------------------------
    // Response checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        timer_rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (rsp_q.size() == 0)
            begin
                $error("unexpected response word: status %0d id %0d",
                       rsp_if.status, rsp_if.found_id);
                mismatches++;
            end
            else
            begin
                want = rsp_q.pop_front();
                check_field("status",       32'(want.status),       32'(rsp_if.status));
                check_field("found_id",     32'(want.found_id),     32'(rsp_if.found_id));
                check_field("remaining_ms", 32'(want.remaining_ms),
                            32'(rsp_if.remaining_ms));
                check_field("found_period", 32'(want.found_period),
                            32'(rsp_if.found_period));
                check_field("found_cycled", 32'(want.found_cycled),
                            32'(rsp_if.found_cycled));
            end
        end
    end

    // watchdog: counts cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [PER_W-1:0] phase_limit [4];
        timer_rsp_t       none;

        none       = '0;
        mismatches = 0;
        quiet      = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        wall       = '0;
        max_limit  = MAX_PERIOD_RST;
        for (int i = 0; i < NUM; i++)
        begin
            slot_live[i]   = 1'b0;
            slot_expiry[i] = '0;
            slot_per[i]    = '0;
            slot_cyc[i]    = 1'b0;
        end

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_if.valid     = 1'b0;
        req_if.mode      = MODE_ADD;
        req_if.task_id   = '0;
        req_if.period_ms = '0;
        req_if.cycled    = 1'b0;
        req_if.now_ms    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script. Comments give the shadow state as it evolves.
        script = '{
            // empty table: peek/pop/remove all miss
            op_is(MODE_PEEK,   4'd0,  31'd0, 1'b0, 32'd0,          STAT_NOT_FOUND),
            op_is(MODE_POP,    4'd0,  31'd0, 1'b0, 32'hFFFF_FFFF,  STAT_NOT_FOUND),
            op_is(MODE_REMOVE, 4'd15, 31'd0, 1'b0, 32'd0,          STAT_NOT_FOUND),
            // id 0 expires at 0
            op_is(MODE_ADD,    4'd0,  31'd0, 1'b0, 32'd0,          STAT_OK),
            op_is(MODE_ADD,    4'd0,  31'd5, 1'b1, 32'd0,          STAT_DUP),
            // period equal to the limit is rejected
            op_is(MODE_ADD,    4'd15, 31'd86400000, 1'b1, 32'd0,   STAT_TOO_LARGE),
            // expiry wraps past zero
            op_is(MODE_ADD,    4'd15, 31'd86399999, 1'b1, 32'hFFFF_FFFF, STAT_OK),
            // id 3 ties with id 0; lower id must win
            op_is(MODE_ADD,    4'd3,  31'd0, 1'b1, 32'd0,          STAT_OK),
            op   (MODE_PEEK,   4'd9,  31'd0, 1'b0, 32'd0),
            // duplicate reported even with an oversized period
            op_is(MODE_ADD,    4'd3,  31'h7FFF_FFFF, 1'b0, 32'd0,  STAT_DUP),
            // expiry already passed: remaining 0, one-shot removed
            op   (MODE_POP,    4'd0,  31'd0, 1'b0, 32'd5),
            // cycled timer re-armed at now + period
            op   (MODE_POP,    4'd0,  31'd0, 1'b0, 32'd5),
            op   (MODE_PEEK,   4'd0,  31'd0, 1'b0, 32'd0),
            op_is(MODE_REMOVE, 4'd3,  31'd0, 1'b0, 32'd0,          STAT_OK),
            op_is(MODE_REMOVE, 4'd3,  31'd0, 1'b0, 32'd0,          STAT_NOT_FOUND),
            op   (MODE_PEEK,   4'd0,  31'd0, 1'b0, 32'h8000_0000),
            limit_row(31'h7FFF_FFFF),
            // largest accepted period, remaining reaches its maximum
            op_is(MODE_ADD,    4'd8,  31'h7FFF_FFFE, 1'b1, 32'd1,  STAT_OK),
            op_is(MODE_REMOVE, 4'd15, 31'd0, 1'b0, 32'd0,          STAT_OK),
            op   (MODE_PEEK,   4'd0,  31'd0, 1'b0, 32'd0),
            limit_row(31'd1),
            op_is(MODE_ADD,    4'd9,  31'd1, 1'b0, 32'd0,          STAT_TOO_LARGE),
            op_is(MODE_ADD,    4'd9,  31'd0, 1'b0, 32'h7FFF_FFFF,  STAT_OK),
            // id 8 re-armed with its stored period although the limit is now 1
            op   (MODE_POP,    4'd0,  31'd0, 1'b0, 32'h7FFF_FFFF),
            op   (MODE_POP,    4'd0,  31'd0, 1'b0, 32'h7FFF_FFFF),
            op   (MODE_PEEK,   4'd0,  31'd0, 1'b0, 32'hFFFF_FFFF)
        };
        foreach (script[i])
        begin
            if (script[i].is_limit)
                write_limit(script[i].limit);
            else
                send_word(script[i].cmd, script[i].typed, script[i].want);
        end

        // Random phases, one per limit setting
        phase_limit[0] = MAX_PERIOD_RST;
        phase_limit[1] = 31'h7FFF_FFFF;
        phase_limit[2] = 31'd1;
        phase_limit[3] = PER_W'($urandom_range(1, 32'h7FFF_FFFF));
        for (int p = 0; p < 4; p++)
        begin
            write_limit(phase_limit[p]);
            if (p == 1)
                hold_req = 1'b1;    // receiver stalls while words keep coming
            if (p == 2)
                calm = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n == CALM_WORDS)
                    calm = 1'b0;
                send_word(next_cmd(), 1'b0, none);
            end
        end
        req_if.valid <= 1'b0;

        // drain, then let the block settle before the verdict
        while (rsp_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
src/ptq_pkg.sv
src/ptq_if.sv
src/ptq_slot_ram.sv
src/periodic_timer_queue.sv
sim/periodic_timer_queue_tb.sv
